@@ design/hbsc_pkg.sv @@
// Package for the HDLC byte-stuffing CRC-8 framer: framing constants,
// the result slot codes, the queued record type and the CRC-8 step function.
// No dependencies.
`timescale 1ns / 1ps

package hbsc_pkg;

   localparam logic [7:0] FLAG_BYTE       = 8'h7E;
   localparam logic [7:0] ESC_BYTE        = 8'h7D;
   localparam logic [7:0] ESC_XOR         = 8'h20;
   localparam logic [7:0] CRC_POLY        = 8'h8C;
   localparam logic [7:0] CRC_SEED        = 8'hFF;
   localparam logic [7:0] ERR_BYTE        = 8'h00;
   localparam logic [7:0] MAX_FRAME_RESET = 8'd64;

   localparam int SLOT_COUNT = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [SLOT_COUNT-1:0] slot_mask_type;

   // One-hot slot codes, in the order the bytes go out.
   localparam slot_mask_type SLOT_OPEN  = 6'b000001;
   localparam slot_mask_type SLOT_ESC   = 6'b000010;
   localparam slot_mask_type SLOT_DATA  = 6'b000100;
   localparam slot_mask_type SLOT_ERROR = 6'b001000;
   localparam slot_mask_type SLOT_CRC   = 6'b010000;
   localparam slot_mask_type SLOT_CLOSE = 6'b100000;

   // Work for the emitter: which slots go out, the (already toggled) data
   // byte and the CRC byte of the trailer.
   typedef struct packed {
      slot_mask_type mask;
      logic [7:0]    data;
      logic [7:0]    crc;
   } rec_type;

   // Reflected CRC-8, one byte, shifting right.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      c = crc;
      d = data;
      for (int k = 0; k < 8; k++) begin
         if ((c[0] ^ d[0]) == 1'b1) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

@@ design/hbsc_req_if.sv @@
// Input channel of the framer: valid/ready handshake with payload byte,
// last mark and empty-frame mark. No dependencies.
`timescale 1ns / 1ps

interface hbsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       empty_frame;

   modport source (output valid, output data_byte, output last, output empty_frame,
                   input ready);
   modport sink   (input valid, input data_byte, input last, input empty_frame,
                   output ready);
endinterface

@@ design/hbsc_rsp_if.sv @@
// Result channel of the framer: valid/ready handshake with the framed byte,
// the per-item last mark and the overflow mark. No dependencies.
`timescale 1ns / 1ps

interface hbsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       overflow;

   modport source (output valid, output out_byte, output out_last, output overflow,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input overflow,
                   output ready);
endinterface

@@ design/hdlc_byte_stuff_crc8_framer_unit.sv @@
// Top level of the HDLC byte-stuffing framer with CRC-8: configuration
// register, front part, record queue and emitter.
// Depends on hbsc_pkg, hbsc_req_if, hbsc_rsp_if, hbsc_front, hbsc_queue, hbsc_back.
`timescale 1ns / 1ps

// The framer takes one payload byte per input transfer and produces the
// framed byte stream on the result channel, one byte per result transfer.
// The first byte of a frame is preceded by the opening flag 0x7E; payload
// bytes equal to 0x7E or 0x7D are sent as 0x7D followed by the byte XOR 0x20.
// After the byte marked last the block sends a reflected CRC-8 (polynomial
// 0x8C, seed 0xFF) over the unescaped payload and a closing flag; the CRC
// byte is sent as is, without escaping. An item marked empty_frame closes the
// open frame, or sends flag, 0xFF, flag between frames. When the opening flag
// plus stuffed payload exceeds max_frame_bytes, one result with overflow set
// and out_byte zero follows that item's bytes, and the rest of the frame is
// discarded up to its last or empty_frame item. out_last marks the final
// result of each input item; items that are discarded give no results.
// Timing: an item is accepted whenever the two-entry record queue has room,
// and the emitter sends one result per cycle while the result port is ready.
// An item gives one result for a plain payload byte inside a frame, two for
// an escaped one, and up to five when it opens the frame, is escaped and
// closes it. The result port is what sets the pace. The first result of an
// item passes through the record queue, the emitter's slot mask register and
// the registered result channel. max_frame_bytes resets to 64 and is written
// through csr_; the user must write it only while the block is idle, which
// the block itself does not enforce.
module hdlc_byte_stuff_crc8_framer_unit (
   input  logic       clock,
   input  logic       reset,
   hbsc_req_if.sink   req,
   hbsc_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import hbsc_pkg::*;

   logic [7:0] max_frame_ff, max_frame_in;
   logic       push;
   rec_type    push_rec;
   logic       queue_full;
   logic       queue_not_empty;
   rec_type    head_rec;
   logic       pop;

   // Frame length limit, counted over the opening flag and stuffed payload.
   assign max_frame_in = csr_write_enable ? csr_write_data : max_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
      end else begin
         max_frame_ff <= max_frame_in;
      end
   end

   // Front part: classifies each item and keeps the CRC and byte count.
   hbsc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .max_frame_bytes (max_frame_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_rec        (push_rec)
   );

   // Records wait here so that input and output can stall independently.
   hbsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_rec  (head_rec)
   );

   // Emitter: walks the slots of each record, one byte per transfer.
   hbsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

@@ design/hbsc_front.sv @@
// Front part of the framer: accepts input transfers, keeps the frame state
// and CRC, and turns each item into a record for the emitter.
// Depends on hbsc_pkg and hbsc_req_if.
`timescale 1ns / 1ps

module hbsc_front (
   input  logic             clock,
   input  logic             reset,
   hbsc_req_if.sink         req,
   input  logic [7:0]       max_frame_bytes,
   input  logic             queue_full,
   output logic             push,
   output hbsc_pkg::rec_type push_rec
);
   import hbsc_pkg::*;

   logic       in_frame_ff, in_frame_in;
   logic       dropping_ff, dropping_in;
   logic [7:0] crc_ff, crc_in;
   logic [8:0] count_ff, count_in;

   logic       accept;
   logic       escaped;
   logic [7:0] crc_base;
   logic [7:0] crc_new;
   logic [8:0] count_base;
   logic [8:0] count_new;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign escaped    = (req.data_byte == FLAG_BYTE) || (req.data_byte == ESC_BYTE);
   assign crc_base   = in_frame_ff ? crc_ff : CRC_SEED;
   assign crc_new    = crc8_update(crc_base, req.data_byte);
   assign count_base = in_frame_ff ? count_ff : 9'd1;
   assign count_new  = count_base + (escaped ? 9'd2 : 9'd1);

   always_comb begin
      in_frame_in   = in_frame_ff;
      dropping_in   = dropping_ff;
      crc_in        = crc_ff;
      count_in      = count_ff;
      push          = 1'b0;
      push_rec.mask = '0;
      push_rec.data = escaped ? (req.data_byte ^ ESC_XOR) : req.data_byte;
      push_rec.crc  = crc_ff;

      if (accept) begin
         if (dropping_ff) begin
            // Discard the rest of an abandoned frame.
            if (req.last || req.empty_frame) begin
               dropping_in = 1'b0;
               in_frame_in = 1'b0;
               crc_in      = CRC_SEED;
               count_in    = '0;
            end
         end else if (req.empty_frame) begin
            push          = 1'b1;
            push_rec.mask = (in_frame_ff ? '0 : SLOT_OPEN) | SLOT_CRC | SLOT_CLOSE;
            push_rec.crc  = crc_ff;
            in_frame_in   = 1'b0;
            crc_in        = CRC_SEED;
            count_in      = '0;
         end else begin
            push          = 1'b1;
            push_rec.crc  = crc_new;
            push_rec.mask = (in_frame_ff ? '0 : SLOT_OPEN) | (escaped ? SLOT_ESC : '0) |
                            SLOT_DATA;
            if (count_new > {1'b0, max_frame_bytes}) begin
               push_rec.mask = push_rec.mask | SLOT_ERROR;
               in_frame_in   = 1'b0;
               crc_in        = CRC_SEED;
               count_in      = '0;
               dropping_in   = !req.last;
            end else if (req.last) begin
               push_rec.mask = push_rec.mask | SLOT_CRC | SLOT_CLOSE;
               in_frame_in   = 1'b0;
               crc_in        = CRC_SEED;
               count_in      = '0;
            end else begin
               in_frame_in = 1'b1;
               crc_in      = crc_new;
               count_in    = count_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         dropping_ff <= 1'b0;
         crc_ff      <= CRC_SEED;
         count_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         dropping_ff <= dropping_in;
         crc_ff      <= crc_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ design/hbsc_queue.sv @@
// Short record queue between the front and the emitter.
// Depends on hbsc_pkg.
`timescale 1ns / 1ps

module hbsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hbsc_pkg::rec_type push_rec,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output hbsc_pkg::rec_type head_rec
);
   import hbsc_pkg::*;

   rec_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_rec  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

@@ design/hbsc_back.sv @@
// Back part of the framer: takes records from the queue and sends their
// bytes one per cycle, while the result channel is ready, through a registered result channel.
// Depends on hbsc_pkg and hbsc_rsp_if.
`timescale 1ns / 1ps

module hbsc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  hbsc_pkg::rec_type head_rec,
   output logic              pop,
   hbsc_rsp_if.source        rsp
);
   import hbsc_pkg::*;

   slot_mask_type mask_ff, mask_in;
   logic [7:0]    data_ff, data_in;
   logic [7:0]    crc_ff, crc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   logic          overflow_ff, overflow_in;

   slot_mask_type sel;
   slot_mask_type rest;
   logic          advance;

   // Lowest pending slot goes out first.
   assign sel     = mask_ff & (~mask_ff + 1'b1);
   assign rest    = mask_ff & ~sel;
   assign advance = (mask_ff != '0) && (!rsp_valid_ff || rsp.ready);
   assign pop     = head_valid && ((mask_ff == '0) || (advance && (rest == '0)));

   always_comb begin
      mask_in      = advance ? rest : mask_ff;
      data_in      = data_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      overflow_in  = overflow_ff;

      if (pop) begin
         mask_in = head_rec.mask;
         data_in = head_rec.data;
         crc_in  = head_rec.crc;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         out_last_in  = (rest == '0);
         overflow_in  = 1'b0;
         unique case (sel)
            SLOT_OPEN:  out_byte_in = FLAG_BYTE;
            SLOT_ESC:   out_byte_in = ESC_BYTE;
            SLOT_DATA:  out_byte_in = data_ff;
            SLOT_ERROR: begin
               out_byte_in = ERR_BYTE;
               overflow_in = 1'b1;
            end
            SLOT_CRC:   out_byte_in = crc_ff;
            SLOT_CLOSE: out_byte_in = FLAG_BYTE;
            default:    out_byte_in = ERR_BYTE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      overflow_ff <= overflow_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.out_last = out_last_ff;
   assign rsp.overflow = overflow_ff;

endmodule

@@ tb/tb_hdlc_byte_stuff_crc8_framer_unit.sv @@
// Self-checking testbench for the HDLC byte-stuffing CRC-8 framer unit.
// Depends on hbsc_pkg, hbsc_req_if, hbsc_rsp_if and hdlc_byte_stuff_crc8_framer_unit.
`timescale 1ns / 1ps

// Payload items are queued by the stimulus process and presented by a clocked
// driver in bursts with random gaps. Each accepted transfer is run through a
// behavioral framer model that appends the framed bytes it should cause to a
// queue of bytes still due. A clocked monitor takes each result transfer and
// compares it with the oldest byte due. The result side stalls on a rotating
// ready pattern that is reloaded periodically. Inputs change at the
// falling edge and everything is sampled at the rising edge.
module tb_hdlc_byte_stuff_crc8_framer_unit;
   import hbsc_pkg::*;

   // Dropped items cause no results; this settling time covers any work still
   // in flight inside the block.
   localparam int SETTLE_CYCLES  = 8;
   // Slowest legal case: five results per item, each behind the longest stall
   // of the result side, plus sender gaps. This is several times that.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RESET_CYCLES   = 12;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       empty;
   } payload_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       ovf;
   } framed_byte_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   hbsc_req_if req_ch ();
   hbsc_rsp_if rsp_ch ();

   hdlc_byte_stuff_crc8_framer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Items waiting for the driver, and framed bytes the block still owes.
   payload_item_type pending_items[$];
   framed_byte_type  framed_bytes_due[$];

   // State of the framer model, plus a copy of the frame limit register.
   logic       fr_open;
   logic       fr_drop;
   logic [7:0] fr_crc;
   logic [8:0] fr_count;
   logic [7:0] fr_limit;

   int fail_count    = 0;
   int items_queued  = 0;
   int items_taken   = 0;
   int bytes_checked = 0;
   int overflow_seen = 0;
   int limits_used   = 0;
   int idle_cycles   = 0;

   logic        req_taken     = 1'b0;
   int          burst_left    = 0;
   int          gap_left      = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int          stall_age     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reflected CRC-8 step: the bits of the byte enter least significant first.
   function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       fb;
      int         i;
      acc = crc;
      for (i = 0; i < 8; i++) begin
         fb  = acc[0] ^ data[i];
         acc = {1'b0, acc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   // Payload bytes lean toward the two bytes that need escaping and the extremes.
   function automatic logic [7:0] random_payload();
      case ($urandom_range(0, 7))
         0:       return FLAG_BYTE;
         1:       return ESC_BYTE;
         2:       return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic fresh_frame();
      fr_open  = 1'b0;
      fr_drop  = 1'b0;
      fr_crc   = CRC_SEED;
      fr_count = 9'd0;
   endtask

   task automatic due_byte(input logic [7:0] value, input logic ovf);
      framed_byte_type fb;
      fb.value = value;
      fb.last  = 1'b0;
      fb.ovf   = ovf;
      framed_bytes_due.push_back(fb);
   endtask

   // Works out the framed bytes that one accepted payload item causes.
   task automatic frame_payload_item(input payload_item_type it);
      int due_before;
      due_before = framed_bytes_due.size();
      if (fr_drop) begin
         // The rest of an abandoned frame is swallowed up to its end.
         if (it.last || it.empty) begin
            fresh_frame();
         end
      end else if (it.empty) begin
         // Closes an open frame, or sends a whole empty frame between frames.
         if (!fr_open) begin
            due_byte(FLAG_BYTE, 1'b0);
         end
         due_byte(fr_crc, 1'b0);
         due_byte(FLAG_BYTE, 1'b0);
         fresh_frame();
      end else begin
         if (!fr_open) begin
            due_byte(FLAG_BYTE, 1'b0);
            fr_open  = 1'b1;
            fr_count = 9'd1;
            fr_crc   = CRC_SEED;
         end
         fr_crc = crc8_maxim_step(fr_crc, it.data);
         if (it.data == FLAG_BYTE || it.data == ESC_BYTE) begin
            due_byte(ESC_BYTE, 1'b0);
            due_byte(it.data ^ ESC_XOR, 1'b0);
            fr_count = fr_count + 9'd2;
         end else begin
            due_byte(it.data, 1'b0);
            fr_count = fr_count + 9'd1;
         end
         // The trailer is not counted, so the limit check comes first.
         if (fr_count > {1'b0, fr_limit}) begin
            due_byte(ERR_BYTE, 1'b1);
            fresh_frame();
            fr_drop = !it.last;
         end else if (it.last) begin
            due_byte(fr_crc, 1'b0);
            due_byte(FLAG_BYTE, 1'b0);
            fresh_frame();
         end
      end
      if (framed_bytes_due.size() > due_before) begin
         framed_bytes_due[framed_bytes_due.size() - 1].last = 1'b1;
      end
   endtask

   // Rising edge: model the accepted item, check the accepted result, and
   // run the watchdog. The watchdog comes last so nothing follows its exit.
   always @(posedge clock) begin : check_side
      payload_item_type got;
      framed_byte_type  want;
      logic             rsp_fire;
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_fire = rsp_ch.valid && rsp_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         got.data  = req_ch.data_byte;
         got.last  = req_ch.last;
         got.empty = req_ch.empty_frame;
         frame_payload_item(got);
         items_taken++;
      end
      if (!reset && rsp_fire) begin
         if (framed_bytes_due.size() == 0) begin
            $error("result with none due: out_byte %02h, out_last %0b, overflow %0b",
                   rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.overflow);
            fail_count++;
         end else begin
            want = framed_bytes_due.pop_front();
            if (rsp_ch.out_byte !== want.value) begin
               $error("out_byte: expected %02h, actual %02h", want.value, rsp_ch.out_byte);
               fail_count++;
            end
            if (rsp_ch.out_last !== want.last) begin
               $error("out_last: expected %0b, actual %0b", want.last, rsp_ch.out_last);
               fail_count++;
            end
            if (rsp_ch.overflow !== want.ovf) begin
               $error("overflow: expected %0b, actual %0b", want.ovf, rsp_ch.overflow);
               fail_count++;
            end
            bytes_checked++;
            if (want.ovf) begin
               overflow_seen++;
            end
         end
      end
      if (reset || (req_ch.valid && req_ch.ready) || rsp_fire) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d bytes still due.",
                  idle_cycles, framed_bytes_due.size());
         $display("hdlc_byte_stuff_crc8_framer_unit test failed");
         $finish;
      end
   end

   // Falling edge: the driver presents the next item once the current one is
   // taken. Bursts of random length alternate with gaps, and about a third of
   // the bursts are followed by no gap at all.
   always @(negedge clock) begin : drive_side
      payload_item_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            nxt = pending_items.pop_front();
            req_ch.data_byte   <= nxt.data;
            req_ch.last        <= nxt.last;
            req_ch.empty_frame <= nxt.empty;
            req_ch.valid       <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Falling edge: the receiver's ready follows a rotating pattern. Patterns
   // range from never stalling to mostly stalled; none is all zeros, so no
   // stall lasts longer than one turn of the pattern.
   always @(negedge clock) begin : accept_side
      if (stall_age == 0) begin
         stall_age = 48;
         case ($urandom_range(0, 3))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'($urandom) | 16'h0001;
            2:       stall_pattern = 16'($urandom | $urandom) | 16'h8001;
            default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
         endcase
      end
      stall_age--;
      rsp_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   task automatic queue_item(input logic [7:0] data, input logic last, input logic empty);
      payload_item_type it;
      it.data  = data;
      it.last  = last;
      it.empty = empty;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Waits until every queued item has been taken and every due byte has
   // come, then lets a dropped item finish inside the block.
   task automatic wait_until_drained();
      while (items_taken != items_queued || framed_bytes_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_limit(input logic [7:0] limit);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      fr_limit = limit;
      limits_used++;
   endtask

   // Mostly well-formed frames with random content; the rest are frames
   // closed by an empty item, whole empty frames and loose random items.
   task automatic add_random_traffic(input int item_budget, input int max_len);
      int added;
      int len;
      int k;
      int kind;
      added = 0;
      while (added < item_budget) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, max_len)
                                              : $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
               queue_item(random_payload(), (kind != 6) && (k == len - 1), 1'b0);
            end
            if (kind == 6) begin
               queue_item(8'($urandom), 1'($urandom), 1'b1);
               len++;
            end
            added += len;
         end else if (kind == 7) begin
            queue_item(8'($urandom), 1'($urandom), 1'b1);
            added++;
         end else begin
            queue_item(8'($urandom), 1'($urandom), 1'($urandom));
            added++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = 8'h00;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = 8'h00;
      req_ch.last        = 1'b0;
      req_ch.empty_frame = 1'b0;
      rsp_ch.ready       = 1'b0;
      fresh_frame();
      fr_limit = MAX_FRAME_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset limit. An empty item between frames
      // ignores its data and last mark.
      queue_item(8'hA5, 1'b1, 1'b1);
      queue_item(8'h00, 1'b1, 1'b0);
      // A lone flag byte opens, is escaped and closes: five results.
      queue_item(FLAG_BYTE, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_item(ESC_BYTE, 1'b0, 1'b0);
      queue_item(8'h20, 1'b0, 1'b0);
      queue_item(8'h5E, 1'b0, 1'b0);
      queue_item(8'h5D, 1'b1, 1'b0);
      // The sender stops mid-frame until the block has sent everything.
      queue_item(8'h41, 1'b0, 1'b0);
      queue_item(ESC_BYTE, 1'b0, 1'b0);
      wait_until_drained();
      queue_item(8'h42, 1'b0, 1'b0);
      // An empty item inside a frame closes it with the CRC and a flag.
      queue_item(8'h99, 1'b0, 1'b1);
      queue_item(8'h80, 1'b1, 1'b0);

      // Smallest limit: overflow on the second byte drops the frame up to its
      // last item; overflow on a last item drops nothing; an empty item also
      // ends a drop; an escaped first byte overflows at once.
      write_frame_limit(8'd2);
      queue_item(8'h11, 1'b0, 1'b0);
      queue_item(8'h22, 1'b0, 1'b0);
      queue_item(8'h33, 1'b0, 1'b0);
      queue_item(8'h44, 1'b1, 1'b0);
      queue_item(ESC_BYTE, 1'b1, 1'b0);
      queue_item(8'h55, 1'b0, 1'b0);
      queue_item(8'h66, 1'b0, 1'b0);
      queue_item(8'h77, 1'b0, 1'b1);
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(FLAG_BYTE, 1'b0, 1'b0);
      queue_item(FLAG_BYTE, 1'b1, 1'b0);
      add_random_traffic(20, 4);

      write_frame_limit(8'd255);
      add_random_traffic(40, 30);

      write_frame_limit(8'($urandom_range(3, 12)));
      add_random_traffic(30, 12);

      write_frame_limit(MAX_FRAME_RESET);
      add_random_traffic(30, 40);

      wait_until_drained();
      $display("Covered %0d input transfers and %0d checked results, %0d of them overflow;",
               items_taken, bytes_checked, overflow_seen);
      $display("the frame limit was rewritten %0d times, down to 2 and up to 255.",
               limits_used);
      if (fail_count == 0) begin
         $display("hdlc_byte_stuff_crc8_framer_unit test passed");
      end else begin
         $display("hdlc_byte_stuff_crc8_framer_unit test failed");
      end
      $finish;
   end

endmodule
